/* hdl/lenenc_field_parser_macros.svh */
// assertion helpers for the length-encoded field parser
`ifndef LENENC_FIELD_PARSER_MACROS_SVH
`define LENENC_FIELD_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define LEF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LEF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define LEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hdl/lef_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lef_pkg;

	localparam int OFFSET_BITS_DEF = 24;
	localparam int VALUE_W = 64;
	localparam int FIELD_OFFSET_W = 24;

	// prefix codes
	localparam logic [7:0] PFX_NULL = 8'hfb;
	localparam logic [7:0] PFX_LEN2 = 8'hfc;
	localparam logic [7:0] PFX_LEN3 = 8'hfd;
	localparam logic [7:0] PFX_LEN8 = 8'hfe;
	localparam logic [7:0] PFX_BAD  = 8'hff;

	typedef struct packed {
		logic [VALUE_W-1:0]        value;
		logic [FIELD_OFFSET_W-1:0] offset;
		logic                      bad;
		logic                      trunc;
	} result_t;

endpackage

`default_nettype wire

/* hdl/lef_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module lef_core #(
	parameter int OFFSET_BITS = lef_pkg::OFFSET_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step_en,
	input  wire logic [7:0]      data_byte,
	input  wire logic            last_byte,
	input  wire logic            string_mode,
	output logic                 res_valid,
	output lef_pkg::result_t     res
);

	typedef enum logic [1:0] {
		PH_PREFIX,
		PH_VALUE,
		PH_STRING
	} phase_t;

	phase_t                          phase_q, n_phase;
	logic [3:0]                      left_q, n_left;
	logic [3:0]                      cnt_q, n_cnt;
	logic [lef_pkg::VALUE_W-1:0]     acc_q, n_acc;
	logic [lef_pkg::VALUE_W-1:0]     str_q, n_str;
	logic [OFFSET_BITS-1:0]          pos_q, n_pos;
	logic [OFFSET_BITS-1:0]          start_q, n_start;
	logic                            bad_q, n_bad;
	logic                            prefix_done;
	logic                            emit;
	logic                            trunc;
	logic [OFFSET_BITS+lef_pkg::FIELD_OFFSET_W-1:0] start_ext;

	always_comb begin
		n_phase     = phase_q;
		n_left      = left_q;
		n_cnt       = cnt_q;
		n_acc       = acc_q;
		n_str       = str_q;
		n_start     = start_q;
		n_bad       = bad_q;
		n_pos       = pos_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
		prefix_done = 1'b0;
		emit        = 1'b0;
		trunc       = 1'b0;

		case (phase_q)
			PH_PREFIX: begin
				n_start = pos_q;
				n_bad   = (data_byte == lef_pkg::PFX_BAD);
				n_acc   = '0;
				n_cnt   = 4'd0;
				if (data_byte < lef_pkg::PFX_NULL) begin
					n_acc       = {{(lef_pkg::VALUE_W-8){1'b0}}, data_byte};
					prefix_done = 1'b1;
				end else if (data_byte == lef_pkg::PFX_NULL) begin
					prefix_done = 1'b1;
				end else begin
					if (data_byte == lef_pkg::PFX_LEN2)
						n_left = 4'd2;
					else if (data_byte == lef_pkg::PFX_LEN3)
						n_left = 4'd3;
					else
						n_left = 4'd8;
					n_phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				// little-endian gather, skipped for the bad prefix
				if (!bad_q && !cnt_q[3])
					n_acc = acc_q | ({{(lef_pkg::VALUE_W-8){1'b0}}, data_byte}
						<< {cnt_q[2:0], 3'b000});
				n_cnt  = cnt_q + 4'd1;
				n_left = left_q - 4'd1;
				if (n_left == 4'd0)
					prefix_done = 1'b1;
			end
			PH_STRING: begin
				n_str = str_q - {{(lef_pkg::VALUE_W-1){1'b0}}, 1'b1};
				if (n_str == '0) begin
					emit    = 1'b1;
					n_phase = PH_PREFIX;
				end
			end
			default: begin
				n_phase = PH_PREFIX;
			end
		endcase

		if (prefix_done) begin
			if (string_mode) begin
				n_start = pos_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
				if (n_acc == '0) begin
					emit    = 1'b1;
					n_phase = PH_PREFIX;
				end else begin
					n_str   = n_acc;
					n_phase = PH_STRING;
				end
			end else begin
				emit    = 1'b1;
				n_phase = PH_PREFIX;
			end
		end

		if (last_byte) begin
			if (n_phase != PH_PREFIX) begin
				emit  = 1'b1;
				trunc = 1'b1;
			end
			n_phase = PH_PREFIX;
			n_left  = 4'd0;
			n_str   = '0;
			n_pos   = '0;
		end
	end

	assign start_ext = {{lef_pkg::FIELD_OFFSET_W{1'b0}}, n_start};
	assign res_valid = emit;
	assign res.value  = n_acc;
	assign res.offset = start_ext[lef_pkg::FIELD_OFFSET_W-1:0];
	assign res.bad    = n_bad;
	assign res.trunc  = trunc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			left_q  <= 4'd0;
			cnt_q   <= 4'd0;
			acc_q   <= '0;
			str_q   <= '0;
			pos_q   <= '0;
			start_q <= '0;
			bad_q   <= 1'b0;
		end else if (step_en) begin
			phase_q <= n_phase;
			left_q  <= n_left;
			cnt_q   <= n_cnt;
			acc_q   <= n_acc;
			str_q   <= n_str;
			pos_q   <= n_pos;
			start_q <= n_start;
			bad_q   <= n_bad;
		end
	end

endmodule

`default_nettype wire

/* hdl/lenenc_field_parser.sv */
// length-encoded field parser
//
// s_* carries one packet payload byte per beat: tdata = data_byte, tlast
// marks the final byte of the packet. m_* carries one beat per field:
// tdata = field_value, field_offset; tuser = bad_prefix, truncated.
// a field is emitted when it completes, or truncated when the packet ends
// inside it. the user must write string_mode (reset 1) via cfg_* only while
// the block is idle; the block itself does not enforce this.
// throughput is one byte per cycle while no held result stalls the step
// stage. a byte is captured in the input register; the field state update
// and the result register load then happen in the same cycle, so a result
// passes the input register, then the result register. the decrement of the
// 64-bit string length and the value gather set the cycle path.
//
// reset clears the parser to expecting a prefix at packet offset zero.
// while m_tready is low a held result stalls the step stage; the input
// register still takes one more byte if it is empty before s_tready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "lenenc_field_parser_macros.svh"

module lenenc_field_parser #(
	parameter int OFFSET_BITS = lef_pkg::OFFSET_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,   // [63:0] field_value, [87:64] field_offset
	output logic [1:0]       m_tuser,   // [0] bad_prefix, [1] truncated
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              mode_q;
	logic              advance;
	logic              step_en;
	logic              res_valid;
	lef_pkg::result_t  res;
	logic              out_valid_q;
	lef_pkg::result_t  out_q;

	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign step_en   = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	lef_core #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (step_en),
		.data_byte   (byte_s1),
		.last_byte   (last_s1),
		.string_mode (mode_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_en && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res_valid)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.offset, out_q.value};
	assign m_tuser  = {out_q.trunc, out_q.bad};

	// a stalled byte in the input register is kept until the step stage runs
	`LEF_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(byte_s1), "input beat lost while stalled")
	// a new result only follows a step of the parser
	`LEF_ASSERT_IMPLIES(a_out_from_step, clk, arst_n, $rose(out_valid_q), $past(step_en), "result beat without a parser step")
	// truncation is only reported on the packet's final byte
	`LEF_ASSERT_IMPLIES(a_trunc_last, clk, arst_n, step_en && res_valid && res.trunc, last_s1, "truncated field away from packet end")

endmodule

`default_nettype wire

/* tb/lenenc_field_parser_test.sv */
`timescale 1ns / 1ps

module lenenc_field_parser_test;

	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_BYTES = 700;
	localparam int SETTLE_CYCLES = 6;
	localparam int RX_HOLD_CYCLES = 400;

	typedef enum logic [1:0] {EXPECT_PREFIX, IN_LENGTH, IN_BODY} parse_phase_t;

	typedef struct packed {
		logic              smode;
		logic [7:0]        data;
		logic              last;
		logic              has_want;
		lef_pkg::result_t  want;
	} dir_row_t;

	localparam lef_pkg::result_t NO_RESULT = '0;

	// string mode rows first (reset value of the register), integer rows at the end
	localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
		// empty strings: zero length and null
		'{1'b1, 8'h00, 1'b0, 1'b1, '{64'd0, 24'd1, 1'b0, 1'b0}},
		'{1'b1, lef_pkg::PFX_NULL, 1'b0, 1'b1, '{64'd0, 24'd2, 1'b0, 1'b0}},
		// bad prefix cut short by the packet end
		'{1'b1, lef_pkg::PFX_BAD, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'haa, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'h55, 1'b1, 1'b1, '{64'd0, 24'd2, 1'b1, 1'b1}},
		// two byte length, two byte body
		'{1'b1, lef_pkg::PFX_LEN2, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'h02, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'h00, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'h78, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'h79, 1'b0, 1'b1, '{64'd2, 24'd3, 1'b0, 1'b0}},
		// largest direct length, body cut by the packet end
		'{1'b1, 8'hfa, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'h41, 1'b1, 1'b1, '{64'd250, 24'd6, 1'b0, 1'b1}},
		// all-ones eight byte length, prefix ends with the packet
		'{1'b1, lef_pkg::PFX_LEN8, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'hff, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'hff, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'hff, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'hff, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'hff, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'hff, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'hff, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'hff, 1'b1, 1'b1, '{64'hffff_ffff_ffff_ffff, 24'd9, 1'b0, 1'b1}},
		// packet ends inside the length bytes
		'{1'b1, lef_pkg::PFX_LEN3, 1'b0, 1'b0, NO_RESULT},
		'{1'b1, 8'h34, 1'b1, 1'b1, '{64'h34, 24'd0, 1'b0, 1'b1}},
		// integer mode: null, then a direct value ending the packet
		'{1'b0, lef_pkg::PFX_NULL, 1'b0, 1'b1, '{64'd0, 24'd0, 1'b0, 1'b0}},
		'{1'b0, 8'hfa, 1'b1, 1'b1, '{64'd250, 24'd1, 1'b0, 1'b0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] data_byte
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;        // [63:0] field_value, [87:64] field_offset
	logic [1:0]  m_tuser;        // [0] bad_prefix, [1] truncated
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	// parser model state
	parse_phase_t                       prs_phase = EXPECT_PREFIX;
	logic [3:0]                         len_bytes_left = '0;
	logic [3:0]                         len_bytes_seen = '0;
	logic [63:0]                        decoded_len = '0;
	logic [63:0]                        body_left = '0;
	logic [lef_pkg::FIELD_OFFSET_W-1:0] pkt_pos = '0;
	logic [lef_pkg::FIELD_OFFSET_W-1:0] fld_start = '0;
	logic                               fld_bad = 1'b0;
	logic                               string_mode = 1'b1;

	lef_pkg::result_t pending_fields[$];
	logic [7:0]       pkt_bytes[$];
	int               mismatches = 0;
	int               bytes_sent = 0;
	bit               tx_steady = 1'b0;
	bit               rx_steady = 1'b0;
	bit               hold_rx = 1'b0;

	lenenc_field_parser i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic lef_pkg::result_t make_field(logic [63:0] value,
	                                                logic [lef_pkg::FIELD_OFFSET_W-1:0] offset,
	                                                logic bad, logic trunc);
		lef_pkg::result_t f;
		f.value = value;
		f.offset = offset;
		f.bad = bad;
		f.trunc = trunc;
		return f;
	endfunction

	// advances the model by one payload byte, returns the field it closes, if any
	task automatic parse_byte(input logic [7:0] b, input logic last, output bit emit,
	                          output lef_pkg::result_t fld);
		logic [lef_pkg::FIELD_OFFSET_W-1:0] pos;
		bit len_done;
		pos = pkt_pos;
		len_done = 1'b0;
		emit = 1'b0;
		fld = NO_RESULT;
		case (prs_phase)
			EXPECT_PREFIX: begin
				fld_start = pos;
				fld_bad = (b == lef_pkg::PFX_BAD);
				decoded_len = '0;
				len_bytes_seen = '0;
				if (b < lef_pkg::PFX_NULL) begin
					decoded_len = 64'(b);
					len_done = 1'b1;
				end else if (b == lef_pkg::PFX_NULL) begin
					len_done = 1'b1;
				end else begin
					len_bytes_left = (b == lef_pkg::PFX_LEN2) ? 4'd2 :
					                 (b == lef_pkg::PFX_LEN3) ? 4'd3 : 4'd8;
					prs_phase = IN_LENGTH;
				end
			end
			IN_LENGTH: begin
				// a bad prefix skips its bytes without gathering them
				if (!fld_bad && len_bytes_seen < 4'd8)
					decoded_len |= 64'(b) << (8 * len_bytes_seen);
				len_bytes_seen = len_bytes_seen + 4'd1;
				len_bytes_left = len_bytes_left - 4'd1;
				if (len_bytes_left == 4'd0)
					len_done = 1'b1;
			end
			default: begin
				body_left = body_left - 64'd1;
				if (body_left == 64'd0) begin
					fld = make_field(decoded_len, fld_start, fld_bad, 1'b0);
					emit = 1'b1;
					prs_phase = EXPECT_PREFIX;
				end
			end
		endcase
		if (len_done) begin
			if (string_mode) begin
				fld_start = pos + 1'b1;
				if (decoded_len == 64'd0) begin
					fld = make_field(64'd0, fld_start, fld_bad, 1'b0);
					emit = 1'b1;
					prs_phase = EXPECT_PREFIX;
				end else begin
					body_left = decoded_len;
					prs_phase = IN_BODY;
				end
			end else begin
				fld = make_field(decoded_len, fld_start, fld_bad, 1'b0);
				emit = 1'b1;
				prs_phase = EXPECT_PREFIX;
			end
		end
		if (last) begin
			if (prs_phase != EXPECT_PREFIX) begin
				fld = make_field(decoded_len, fld_start, fld_bad, 1'b1);
				emit = 1'b1;
			end
			prs_phase = EXPECT_PREFIX;
			len_bytes_left = '0;
			body_left = '0;
			pkt_pos = '0;
		end else begin
			pkt_pos = pos + 1'b1;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// offers one byte until it is taken, then records the field it should close
	task automatic push_byte(input logic [7:0] b, input logic last, input bit use_given,
	                         input lef_pkg::result_t given);
		int gap;
		bit emit;
		lef_pkg::result_t fld;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		parse_byte(b, last, emit, fld);
		if (use_given)
			pending_fields.push_back(given);
		else if (emit)
			pending_fields.push_back(fld);
	endtask

	// waits for the block to drain, then writes string_mode
	task automatic set_mode(input logic mode);
		s_tvalid <= 1'b0;
		while (pending_fields.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		string_mode = mode;
	endtask

	// appends one field, at times with a bad prefix; string lengths stay short to keep bodies cheap
	task automatic gen_field(input logic smode);
		int kind;
		int nlen;
		logic [63:0] val;
		logic [7:0] pfx;
		kind = $urandom_range(0, 19);
		if (smode)
			val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
		else
			val = {$urandom, $urandom};
		if (kind < 8) begin
			nlen = 0;
			if (!smode)
				val = $urandom_range(0, 250);
			pfx = val[7:0];
		end else if (kind == 8) begin
			nlen = 0;
			val = '0;
			pfx = lef_pkg::PFX_NULL;
		end else if (kind < 12) begin
			nlen = 2;
			pfx = lef_pkg::PFX_LEN2;
			if (!smode)
				val[63:16] = '0;
		end else if (kind < 15) begin
			nlen = 3;
			pfx = lef_pkg::PFX_LEN3;
			if (!smode)
				val[63:24] = '0;
		end else if (kind < 19) begin
			nlen = 8;
			pfx = lef_pkg::PFX_LEN8;
		end else begin
			nlen = 8;
			pfx = lef_pkg::PFX_BAD;
		end
		pkt_bytes.push_back(pfx);
		for (int i = 0; i < nlen; i++)
			pkt_bytes.push_back((pfx == lef_pkg::PFX_BAD) ? 8'($urandom) : val[8*i +: 8]);
		if (smode && pfx != lef_pkg::PFX_BAD)
			repeat (val) pkt_bytes.push_back(8'($urandom));
	endtask

	task automatic send_packet(input bit end_packet);
		for (int i = 0; i < pkt_bytes.size(); i++)
			push_byte(pkt_bytes[i], end_packet && (i == pkt_bytes.size() - 1), 1'b0, NO_RESULT);
	endtask

	initial begin
		int phase_no;
		int kind;
		logic phase_mode;
		@(posedge clk);
		while (!arst_n) @(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (DIRECTED[r].smode != string_mode)
				set_mode(DIRECTED[r].smode);
			push_byte(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].has_want, DIRECTED[r].want);
		end

		phase_no = 0;
		while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES) begin
			phase_mode = (phase_no == 0) ? 1'b0 : (phase_no == 1) ? 1'b1
			                                    : 1'($urandom_range(0, 1));
			if (phase_mode != string_mode)
				set_mode(phase_mode);
			tx_steady = (phase_no == 0) || ($urandom_range(0, 3) == 0);
			// first phase: back-to-back integer fields against a stalled output
			if (phase_no == 0 || $urandom_range(0, 5) == 0)
				hold_rx = 1'b1;
			repeat ($urandom_range(3, 10)) begin
				pkt_bytes.delete();
				kind = $urandom_range(0, 9);
				if (kind == 0)
					repeat ($urandom_range(1, 10)) pkt_bytes.push_back(8'($urandom));
				else
					repeat ($urandom_range(1, 5)) gen_field(string_mode);
				if (kind == 1 && pkt_bytes.size() > 1)
					pkt_bytes = pkt_bytes[0:$urandom_range(0, pkt_bytes.size() - 2)];
				send_packet(1'b1);
			end
			// sometimes leave a field open across the mode write
			if ($urandom_range(0, 2) == 0) begin
				pkt_bytes.delete();
				gen_field(string_mode);
				pkt_bytes = pkt_bytes[0:$urandom_range(0, pkt_bytes.size() - 1)];
				send_packet(1'b0);
			end
			phase_no++;
		end

		s_tvalid <= 1'b0;
		while (pending_fields.size() != 0) @(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("lenenc_field_parser regression: pass");
		else
			$display("lenenc_field_parser regression: fail");
		$finish;
	end

	initial begin
		int rx_gap;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end
			rx_gap = rx_steady ? 0 : pick_gap();
			if (rx_gap > 0) begin
				m_tready <= 1'b0;
				repeat (rx_gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			if ($urandom_range(0, 149) == 0)
				rx_steady = !rx_steady;
			@(posedge clk);
		end
	end

	function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : field_check
		lef_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_fields.size() == 0) begin
				$display("%0t: field beat with nothing expected, tdata %h tuser %b",
				         $time, m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = pending_fields.pop_front();
				check_field("field_value", want.value, m_tdata[63:0]);
				check_field("field_offset", 64'(want.offset), 64'(m_tdata[87:64]));
				check_field("bad_prefix", 64'(want.bad), 64'(m_tuser[0]));
				check_field("truncated", 64'(want.trunc), 64'(m_tuser[1]));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("lenenc_field_parser regression: fail");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/lef_pkg.sv
hdl/lef_core.sv
hdl/lenenc_field_parser.sv
tb/lenenc_field_parser_test.sv
